FILE: src/kuznyechik_linear_layer_defines.svh
// assertion macros for the linear layer
`ifndef KUZNYECHIK_LINEAR_LAYER_DEFINES_SVH
`define KUZNYECHIK_LINEAR_LAYER_DEFINES_SVH

`ifndef SYNTHESIS
`define KLL_ASSERT_DIS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("assertion failed");
`define KLL_ASSERT(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define KLL_ASSERT_DIS(label, clk, rst_n, prop)
`define KLL_ASSERT(label, clk, prop)
`endif

`endif

FILE: src/kll_pkg.sv
package kll_pkg;

    localparam int HALF_W     = 64;
    localparam int NUM_BYTES  = 16;
    localparam int NUM_ROUNDS = 16;
    localparam int NUM_W      = NUM_BYTES - 1;

    localparam logic [7:0] GF_REDUCE = 8'hC3;
    localparam logic [7:0] GF_TOPBIT = 8'h80;

    localparam logic FUNC_FWD = 1'b0;
    localparam logic FUNC_INV = 1'b1;

    localparam logic [7:0] WEIGHT [NUM_W] = '{
        8'h94, 8'h20, 8'h85, 8'h10, 8'hC2, 8'hC0, 8'h01, 8'hFB,
        8'h01, 8'hC0, 8'hC2, 8'h10, 8'h85, 8'h20, 8'h94
    };

    typedef logic [NUM_BYTES-1:0][7:0] t_block;

    // with a constant y this folds into a small xor network
    function automatic logic [7:0] gf_mul(input logic [7:0] x, input logic [7:0] y);
        logic [7:0] acc;
        logic [7:0] m;
        acc = '0;
        m   = x;
        for (int k = 0; k < 8; k++) begin
            if (y[k]) begin
                acc = acc ^ m;
            end
            m = {m[6:0], 1'b0} ^ (((m & GF_TOPBIT) != 8'h00) ? GF_REDUCE : 8'h00);
        end
        return acc;
    endfunction

endpackage

FILE: src/kuznyechik_linear_layer.sv
// pipeline: one register stage per round, from start to o_valid
// throughput: one item per cycle, busy is always low
// results are shown for one cycle on o_valid; the receiver cannot stall
// reset (synchronous, active low) clears the stage valid bits only
`include "kuznyechik_linear_layer_defines.svh"

module kuznyechik_linear_layer (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_func,
    input  logic [kll_pkg::HALF_W-1:0] i_block_lo,
    input  logic [kll_pkg::HALF_W-1:0] i_block_hi,
    output logic                       o_valid,
    output logic [kll_pkg::HALF_W-1:0] o_result_lo,
    output logic [kll_pkg::HALF_W-1:0] o_result_hi
);
    import kll_pkg::*;

    logic   s_valid [NUM_ROUNDS+1];
    logic   s_func  [NUM_ROUNDS+1];
    t_block s_block [NUM_ROUNDS+1];

    assign busy       = 1'b0;
    assign s_valid[0] = start && !busy;
    assign s_func[0]  = i_func;
    assign s_block[0] = {i_block_hi, i_block_lo};

    for (genvar r = 0; r < NUM_ROUNDS; r++) begin : g_round
        kll_round u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (s_valid[r]),
            .i_func  (s_func[r]),
            .i_block (s_block[r]),
            .o_valid (s_valid[r+1]),
            .o_func  (s_func[r+1]),
            .o_block (s_block[r+1])
        );
    end

    assign o_valid     = s_valid[NUM_ROUNDS];
    assign o_result_lo = s_block[NUM_ROUNDS][NUM_BYTES/2-1:0];
    assign o_result_hi = s_block[NUM_ROUNDS][NUM_BYTES-1:NUM_BYTES/2];

    `KLL_ASSERT_DIS(a_item_out, i_clk, i_rst_n, (start && !busy) |-> ##NUM_ROUNDS o_valid)
    `KLL_ASSERT_DIS(a_no_stray, i_clk, i_rst_n, o_valid |-> $past(start && !busy, NUM_ROUNDS))
    `KLL_ASSERT(a_reset_clears, i_clk, !i_rst_n |=> !o_valid)

endmodule

FILE: src/kll_round.sv
module kll_round (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_func,
    input  kll_pkg::t_block i_block,
    output logic           o_valid,
    output logic           o_func,
    output kll_pkg::t_block o_block
);
    import kll_pkg::*;

    logic   r_valid;
    logic   r_func;
    t_block r_block;
    t_block n_block;
    t_block fwd_block;
    t_block inv_block;
    logic [7:0] fwd_fb;
    logic [7:0] inv_fb;

    always_comb begin
        fwd_fb = i_block[NUM_BYTES-1];
        inv_fb = i_block[0];
        for (int j = 0; j < NUM_W; j++) begin
            fwd_fb = fwd_fb ^ gf_mul(i_block[j], WEIGHT[j]);
            inv_fb = inv_fb ^ gf_mul(i_block[j+1], WEIGHT[j]);
        end
        // forward moves bytes up, inverse moves them down
        for (int j = 0; j < NUM_W; j++) begin
            fwd_block[j+1] = i_block[j];
            inv_block[j]   = i_block[j+1];
        end
        fwd_block[0]           = fwd_fb;
        inv_block[NUM_BYTES-1] = inv_fb;
        n_block = (i_func == FUNC_INV) ? inv_block : fwd_block;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func  <= i_func;
        r_block <= n_block;
    end

    assign o_valid = r_valid;
    assign o_func  = r_func;
    assign o_block = r_block;

endmodule

FILE: tb/sv/kuznyechik_linear_layer_test.sv
`default_nettype none

module kuznyechik_linear_layer_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int W = kll_pkg::HALF_W;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_PER_PHASE = 475;

    localparam logic [7:0] FIELD_REDUCE = 8'hC3;
    localparam logic [7:0] L_WEIGHT [15] = '{
        8'h94, 8'h20, 8'h85, 8'h10, 8'hC2, 8'hC0, 8'h01, 8'hFB,
        8'h01, 8'hC0, 8'hC2, 8'h10, 8'h85, 8'h20, 8'h94
    };

    typedef logic [15:0][7:0] block_bytes_t;

    typedef struct {
        logic         func;
        logic [W-1:0] lo;
        logic [W-1:0] hi;
        int unsigned  gap;
        bit           drain_first;
    } l_request_t;

    typedef struct {
        logic [W-1:0] lo;
        logic [W-1:0] hi;
    } l_block_t;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         start = 1'b0;
    logic         busy;
    logic         i_func = 1'b0;
    logic [W-1:0] i_block_lo = '0;
    logic [W-1:0] i_block_hi = '0;
    logic         o_valid;
    logic [W-1:0] o_result_lo;
    logic [W-1:0] o_result_hi;

    l_request_t  request_q[$];
    l_block_t    awaited_blocks[$];
    bit          holding = 1'b0;
    bit          accepted_now = 1'b0;
    int unsigned gap_left = 0;
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;

    kuznyechik_linear_layer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_func     (i_func),
        .i_block_lo (i_block_lo),
        .i_block_hi (i_block_hi),
        .o_valid    (o_valid),
        .o_result_lo(o_result_lo),
        .o_result_hi(o_result_hi)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] m;
        acc = '0;
        m   = a;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) begin
                acc ^= m;
            end
            m = {m[6:0], 1'b0} ^ (m[7] ? FIELD_REDUCE : 8'h00);
        end
        return acc;
    endfunction

    function automatic block_bytes_t l_transform(input logic func, input block_bytes_t blk);
        block_bytes_t b;
        logic [7:0]   fb;
        b = blk;
        for (int r = 0; r < 16; r++) begin
            if (func == kll_pkg::FUNC_INV) begin
                // shift down, feedback lands in the top byte
                fb = b[0];
                for (int j = 0; j < 15; j++) begin
                    b[j] = b[j + 1];
                    fb ^= gf_times(b[j], L_WEIGHT[j]);
                end
                b[15] = fb;
            end else begin
                fb = b[15];
                for (int j = 14; j >= 0; j--) begin
                    fb ^= gf_times(b[j], L_WEIGHT[j]);
                    b[j + 1] = b[j];
                end
                b[0] = fb;
            end
        end
        return b;
    endfunction

    function automatic int unsigned idle_gap(input int unsigned idle_pct);
        int unsigned n;
        n = 0;
        while (n < 40 && $urandom_range(99) < idle_pct) begin
            n++;
        end
        return n;
    endfunction

    task automatic add_request(input logic func, input logic [W-1:0] lo,
                               input logic [W-1:0] hi, input int unsigned gap,
                               input bit drain_first);
        l_request_t req;
        req.func        = func;
        req.lo          = lo;
        req.hi          = hi;
        req.gap         = gap;
        req.drain_first = drain_first;
        request_q.push_back(req);
    endtask

    // driver: one item on the bus until it is taken, then the gap after it
    always @(negedge i_clk) begin
        l_request_t req;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!(holding && !accepted_now)) begin
            holding = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (request_q.size() > 0 &&
                         !(request_q[0].drain_first && awaited_blocks.size() != 0)) begin
                req = request_q.pop_front();
                i_func     <= req.func;
                i_block_lo <= req.lo;
                i_block_hi <= req.hi;
                start      <= 1'b1;
                holding    = 1'b1;
                gap_left   = req.gap;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: check results, then record what the accepted item must give
    always @(posedge i_clk) begin
        l_block_t     got;
        l_block_t     want;
        block_bytes_t res;
        accepted_now <= i_rst_n && start && !busy;
        if (i_rst_n) begin
            if (o_valid) begin
                got.lo = o_result_lo;
                got.hi = o_result_hi;
                if (awaited_blocks.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("unexpected result: lo=%h hi=%h", got.lo, got.hi);
                    end
                end else begin
                    want = awaited_blocks.pop_front();
                    if (got.lo !== want.lo || got.hi !== want.hi) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("result mismatch: lo exp %h got %h, hi exp %h got %h",
                                     want.lo, got.lo, want.hi, got.hi);
                        end
                    end
                end
            end
            if (start && !busy) begin
                res = l_transform(i_func, {i_block_hi, i_block_lo});
                want.lo = res[7:0];
                want.hi = res[15:8];
                awaited_blocks.push_back(want);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("kuznyechik_linear_layer verification failed");
            $finish;
        end
    end

    initial begin
        int unsigned idle_pct [4];
        logic [W-1:0] lo;
        logic [W-1:0] hi;
        block_bytes_t sparse;

        idle_pct = '{0, 72, 0, 28};

        // directed: zero, ones, top bits, single bytes at both ends, checkerboards
        for (int f = 0; f < 2; f++) begin
            add_request(f[0], '0, '0, 0, 1'b0);
            add_request(f[0], '1, '1, 0, 1'b0);
            add_request(f[0], {8{8'h80}}, {8{8'h80}}, 0, 1'b0);
            add_request(f[0], 64'h01, '0, 0, 1'b0);
            add_request(f[0], '0, 64'h01 << 56, 0, 1'b0);
            add_request(f[0], {8{8'h55}}, {8{8'hAA}}, 0, 1'b0);
            add_request(f[0], {8{8'hAA}}, {8{8'h55}}, 0, 1'b0);
            add_request(f[0], 64'hFF, '0, 0, 1'b0);
        end

        for (int p = 0; p < 4; p++) begin
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                if ($urandom_range(3) == 0) begin
                    // mostly zero block with one live byte
                    sparse = '0;
                    sparse[$urandom_range(15)] = 8'($urandom);
                    lo = sparse[7:0];
                    hi = sparse[15:8];
                end else begin
                    lo = {$urandom, $urandom};
                    hi = {$urandom, $urandom};
                end
                add_request(1'($urandom_range(1)), lo, hi, idle_gap(idle_pct[p]),
                            n == 0 && p > 0);
            end
        end

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (request_q.size() != 0 || holding) begin
            @(posedge i_clk);
        end
        while (awaited_blocks.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("kuznyechik_linear_layer verification clean");
        end else begin
            $display("kuznyechik_linear_layer verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
